### rtl/palette_frame_bilinear_scaler_unit_assert.svh
// Assertion macros shared by the palette frame scaler RTL.
// Needs nothing but a clock and an active-low reset in the calling scope.
`ifndef PALETTE_FRAME_BILINEAR_SCALER_UNIT_ASSERT_SVH
`define PALETTE_FRAME_BILINEAR_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfbs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfbs assertion failed");

`endif

### rtl/pfbs_pkg.sv
// Package for the palette frame scaler: sizes, codes, palette and the
// structs passed between the mapping, fetch and blend units. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfbs_pkg;

  localparam int WORDS_PER_ROW  = 53;
  localparam int ROW_COUNT      = 312;
  localparam int PIXELS_IN_WORD = 8;
  localparam int FRACTION_BITS  = 16;

  localparam int FRAME_DEPTH = WORDS_PER_ROW * ROW_COUNT;
  localparam int ROW_PIXELS  = WORDS_PER_ROW * PIXELS_IN_WORD;
  localparam int FX_ONE      = 1 << FRACTION_BITS;
  localparam int TOP_FRAC    = (999 * FX_ONE) / 1000;

  localparam int ADDR_W     = 15;
  localparam int WORD_W     = 32;
  localparam int DEST_W     = 14;
  localparam int SCALE_W    = 25;
  localparam int LINE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int CHAN_W     = 8;
  localparam int NIB_W      = 4;
  localparam int COL_W      = $clog2(ROW_PIXELS);
  localparam int ROW_W      = $clog2(ROW_COUNT);
  localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SUB_W      = $clog2(PIXELS_IN_WORD);
  localparam int FRAC_W     = FRACTION_BITS;
  localparam int PROD_W     = DEST_W + 1 + SCALE_W;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LINE = 2'd0,
    CFG_SCALE_X    = 2'd1,
    CFG_SCALE_Y    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  // One beat from the mapping unit to the fetch unit.
  typedef struct packed {
    logic                         sample;
    logic [ADDR_W-1:0]            waddr;
    logic [WORD_W-1:0]            wdata;
    logic [3:0][ADDR_W-1:0]       addr;
    logic [3:0][SUB_W-1:0]        sub;
    logic [FRAC_W-1:0]            fx;
    logic [FRAC_W-1:0]            fy;
  } fetch_req_t;

  // Four neighbor indices and the weights, from fetch to blend.
  typedef struct packed {
    logic [3:0][NIB_W-1:0] idx;
    logic [FRAC_W-1:0]     fx;
    logic [FRAC_W-1:0]     fy;
  } quad_t;

  // Element 2 is red, 1 is green, 0 is blue.
  function automatic rgb_t palette(input logic [NIB_W-1:0] i);
    rgb_t c;
    case (i)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd255, 8'd255, 8'd255};
      4'd2:    c = {8'd190, 8'd26,  8'd36};
      4'd3:    c = {8'd48,  8'd230, 8'd198};
      4'd4:    c = {8'd180, 8'd26,  8'd226};
      4'd5:    c = {8'd31,  8'd210, 8'd30};
      4'd6:    c = {8'd33,  8'd27,  8'd174};
      4'd7:    c = {8'd223, 8'd246, 8'd10};
      4'd8:    c = {8'd184, 8'd65,  8'd4};
      4'd9:    c = {8'd106, 8'd51,  8'd4};
      4'd10:   c = {8'd254, 8'd74,  8'd87};
      4'd11:   c = {8'd66,  8'd69,  8'd64};
      4'd12:   c = {8'd112, 8'd116, 8'd111};
      4'd13:   c = {8'd89,  8'd254, 8'd89};
      4'd14:   c = {8'd85,  8'd83,  8'd254};
      default: c = {8'd164, 8'd167, 8'd162};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/pfbs_if.sv
// Valid/ready channel interfaces for the sample/write input and the pixel output.
// Depends on pfbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pfbs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [pfbs_pkg::ADDR_W-1:0]      word_address;
  logic [pfbs_pkg::WORD_W-1:0]      word_data;
  logic [pfbs_pkg::DEST_W-1:0]      dest_x;
  logic [pfbs_pkg::DEST_W-1:0]      dest_y;

  modport source (output valid, action, word_address, word_data, dest_x, dest_y,
                  input ready);
  modport sink (input valid, action, word_address, word_data, dest_x, dest_y,
                output ready);
endinterface

interface pfbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfbs_pkg::CHAN_W-1:0]  red;
  logic [pfbs_pkg::CHAN_W-1:0]  green;
  logic [pfbs_pkg::CHAN_W-1:0]  blue;
  logic [pfbs_pkg::CHAN_W-1:0]  alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

### rtl/pfbs_map.sv
// Configuration registers and the three-stage coordinate mapping pipeline.
// Depends on pfbs_pkg and pfbs_in_if; feeds fetch requests to pfbs_fetch.
`timescale 1ns / 1ps
`default_nettype none
module pfbs_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pfbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  pfbs_in_if.sink                           in_bus,
  output pfbs_pkg::fetch_req_t              req,
  output logic                              req_valid,
  input  logic                              req_ready
);
  import pfbs_pkg::*;

  localparam logic [PROD_W-1:0] P_ONE   = PROD_W'(FX_ONE);
  localparam logic [PROD_W-1:0] X_LIMIT = PROD_W'(ROW_PIXELS - 1) << FRACTION_BITS;
  localparam logic [PROD_W-1:0] Y_LIMIT = PROD_W'(ROW_COUNT - 1) << FRACTION_BITS;

  logic [LINE_W-1:0]  start_line_r;
  logic [SCALE_W-1:0] scale_x_r;
  logic [SCALE_W-1:0] scale_y_r;

  // Stage 1: scaled coordinates.
  logic               s1_v_r;
  logic               s1_sample_r;
  logic [ADDR_W-1:0]  s1_waddr_r;
  logic [WORD_W-1:0]  s1_wdata_r;
  logic [PROD_W-1:0]  s1_px_r;
  logic [PROD_W-1:0]  s1_py_r;
  // Stage 2: integer position and fraction.
  logic               s2_v_r;
  logic               s2_sample_r;
  logic [ADDR_W-1:0]  s2_waddr_r;
  logic [WORD_W-1:0]  s2_wdata_r;
  logic [IDX_W-1:0]   s2_x0_r;
  logic [IDX_W-1:0]   s2_y0_r;
  logic [FRAC_W-1:0]  s2_fx_r;
  logic [FRAC_W-1:0]  s2_fy_r;
  // Stage 3: word addresses.
  logic               s3_v_r;
  fetch_req_t         s3_r;

  logic s1_rdy, s2_rdy, s3_rdy;
  logic [IDX_W+FRAC_W-1:0] mx, my;
  logic [LINE_W-1:0]  start_mod;
  logic [ROW_W:0]     r0_sum, r1_sum;
  logic [ROW_W-1:0]   row0, row1;
  logic [IDX_W-1:0]   x1;
  fetch_req_t         s3_nxt;

  // Source point per axis; past the last pixel the second-last pixel is used
  // with a weight just below one.
  function automatic logic [IDX_W+FRAC_W-1:0] map_axis(
    input logic [PROD_W-1:0] p,
    input logic [PROD_W-1:0] lim,
    input logic [IDX_W-1:0]  i_top
  );
    logic [PROD_W-1:0] pt;
    pt = (p <= P_ONE) ? '0 : ((p - P_ONE) >> 1);
    if (pt >= lim) begin
      return {i_top, FRAC_W'(TOP_FRAC)};
    end
    return pt[IDX_W+FRAC_W-1:0];
  endfunction

  assign s3_rdy = !s3_v_r || req_ready;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_bus.ready = s1_rdy;
  assign req_valid = s3_v_r;
  assign req = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_line_r <= '0;
      scale_x_r    <= SCALE_W'(FX_ONE);
      scale_y_r    <= SCALE_W'(FX_ONE);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START_LINE: start_line_r <= cfg_data[LINE_W-1:0];
        CFG_SCALE_X:    scale_x_r    <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:    scale_y_r    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mx = map_axis(s1_px_r, X_LIMIT, IDX_W'(ROW_PIXELS - 2));
    my = map_axis(s1_py_r, Y_LIMIT, IDX_W'(ROW_COUNT - 2));
  end

  // Row rotation: each sum stays below twice the row count.
  always_comb begin
    start_mod = (start_line_r >= LINE_W'(ROW_COUNT)) ?
                start_line_r - LINE_W'(ROW_COUNT) : start_line_r;
    r0_sum = (ROW_W+1)'(s2_y0_r) + (ROW_W+1)'(start_mod);
    row0   = (r0_sum >= (ROW_W+1)'(ROW_COUNT)) ?
             ROW_W'(r0_sum - (ROW_W+1)'(ROW_COUNT)) : ROW_W'(r0_sum);
    r1_sum = (ROW_W+1)'(row0) + (ROW_W+1)'(1);
    row1   = (r1_sum >= (ROW_W+1)'(ROW_COUNT)) ?
             ROW_W'(r1_sum - (ROW_W+1)'(ROW_COUNT)) : ROW_W'(r1_sum);
    x1     = s2_x0_r + IDX_W'(1);

    s3_nxt.sample = s2_sample_r;
    s3_nxt.waddr  = s2_waddr_r;
    s3_nxt.wdata  = s2_wdata_r;
    s3_nxt.fx     = s2_fx_r;
    s3_nxt.fy     = s2_fy_r;
    s3_nxt.addr[0] = ADDR_W'(row0) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(s2_x0_r >> SUB_W);
    s3_nxt.addr[1] = ADDR_W'(row0) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(x1 >> SUB_W);
    s3_nxt.addr[2] = ADDR_W'(row1) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(s2_x0_r >> SUB_W);
    s3_nxt.addr[3] = ADDR_W'(row1) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(x1 >> SUB_W);
    s3_nxt.sub[0] = s2_x0_r[SUB_W-1:0];
    s3_nxt.sub[1] = x1[SUB_W-1:0];
    s3_nxt.sub[2] = s2_x0_r[SUB_W-1:0];
    s3_nxt.sub[3] = x1[SUB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_bus.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
    if (s1_rdy) begin
      s1_sample_r <= (action_t'(in_bus.action) == ACT_SAMPLE);
      s1_waddr_r  <= in_bus.word_address;
      s1_wdata_r  <= in_bus.word_data;
      s1_px_r     <= PROD_W'({in_bus.dest_x, 1'b1}) * PROD_W'(scale_x_r);
      s1_py_r     <= PROD_W'({in_bus.dest_y, 1'b1}) * PROD_W'(scale_y_r);
    end
    if (s2_rdy) begin
      s2_sample_r <= s1_sample_r;
      s2_waddr_r  <= s1_waddr_r;
      s2_wdata_r  <= s1_wdata_r;
      s2_x0_r     <= mx[IDX_W+FRAC_W-1:FRAC_W];
      s2_fx_r     <= mx[FRAC_W-1:0];
      s2_y0_r     <= my[IDX_W+FRAC_W-1:FRAC_W];
      s2_fy_r     <= my[FRAC_W-1:0];
    end
    if (s3_rdy) s3_r <= s3_nxt;
  end

endmodule
`default_nettype wire

### rtl/pfbs_fetch.sv
// Frame memory (single port, registered read) and the read sequencer that
// gathers four neighbor indices per sample. Depends on pfbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfbs_fetch (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfbs_pkg::fetch_req_t  req,
  input  logic                  req_valid,
  output logic                  req_ready,
  output pfbs_pkg::quad_t       quad,
  output logic                  quad_valid,
  input  logic                  quad_ready
);
  import pfbs_pkg::*;
  `include "palette_frame_bilinear_scaler_unit_assert.svh"

  localparam logic [1:0] SLOT_LAST = 2'd3;

  logic [WORD_W-1:0] mem [FRAME_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic                     f_v_r;
  fetch_req_t               f_r;
  logic [1:0]               f_cnt_r;
  logic [3:0][NIB_W-1:0]    f_idx_r;

  logic                     tag_v_r;
  logic [1:0]               tag_slot_r;
  logic [SUB_W-1:0]         tag_sub_r;

  logic                     d_v_r;
  logic                     d_pend_r;
  quad_t                    d_r;

  logic [NIB_W-1:0]         nib;
  logic [WORD_W-1:0]        rshift;
  logic [3:0][NIB_W-1:0]    idx_cur;
  logic                     d_fire, is_write, issue, last_issue, f_release;
  logic                     mem_we, mem_re;

  always_comb begin
    rshift  = rdata_r >> {tag_sub_r, 2'b00};
    nib     = rshift[NIB_W-1:0];
    idx_cur = f_idx_r;
    if (tag_v_r && tag_slot_r != SLOT_LAST) idx_cur[tag_slot_r] = nib;
  end

  // The last read may issue only when the done register is free next cycle.
  assign d_fire     = d_v_r && !d_pend_r && quad_ready;
  assign is_write   = f_v_r && !f_r.sample;
  assign issue      = f_v_r && f_r.sample &&
                      (f_cnt_r != SLOT_LAST || !d_v_r || d_fire);
  assign last_issue = issue && (f_cnt_r == SLOT_LAST);
  assign f_release  = is_write || last_issue;
  assign req_ready  = !f_v_r || f_release;
  assign mem_we     = is_write && (f_r.waddr < ADDR_W'(FRAME_DEPTH));
  assign mem_re     = issue;
  assign quad       = d_r;
  assign quad_valid = d_v_r && !d_pend_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[f_r.waddr] <= f_r.wdata;
    end else if (mem_re) begin
      rdata_r <= mem[f_r.addr[f_cnt_r]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r    <= 1'b0;
      f_cnt_r  <= '0;
      tag_v_r  <= 1'b0;
      d_v_r    <= 1'b0;
      d_pend_r <= 1'b0;
    end else begin
      tag_v_r <= issue;
      if (req_ready) begin
        f_v_r   <= req_valid;
        f_cnt_r <= '0;
      end else if (issue) begin
        f_cnt_r <= f_cnt_r + 2'd1;
      end
      if (last_issue) begin
        d_v_r    <= 1'b1;
        d_pend_r <= 1'b1;
      end else begin
        if (d_fire) d_v_r <= 1'b0;
        d_pend_r <= 1'b0;
      end
    end
    tag_slot_r <= f_cnt_r;
    tag_sub_r  <= f_r.sub[f_cnt_r];
    f_idx_r    <= idx_cur;
    if (req_ready && req_valid) f_r <= req;
    if (last_issue) begin
      d_r.idx <= idx_cur;
      d_r.fx  <= f_r.fx;
      d_r.fy  <= f_r.fy;
    end else if (d_pend_r) begin
      d_r.idx[SLOT_LAST] <= nib;
    end
  end

  `PFBS_ASSERT_NOW(a_pend_has_data, clk, rst_n, d_pend_r,
    tag_v_r && tag_slot_r == SLOT_LAST)
  `PFBS_ASSERT_NOW(a_port_exclusive, clk, rst_n, mem_we, !mem_re)
  `PFBS_ASSERT_NOW(a_done_space, clk, rst_n, last_issue, !d_v_r || d_fire)
  `PFBS_ASSERT_NEXT(a_last_sets_pend, clk, rst_n, last_issue, d_pend_r && d_v_r)

endmodule
`default_nettype wire

### rtl/pfbs_blend.sv
// Palette lookup and two-stage bilinear blend with the output register.
// Depends on pfbs_pkg and pfbs_out_if.
`timescale 1ns / 1ps
`default_nettype none
module pfbs_blend (
  input  logic             clk,
  input  logic             rst_n,
  input  pfbs_pkg::quad_t  quad,
  input  logic             quad_valid,
  output logic             quad_ready,
  pfbs_out_if.source       out_bus
);
  import pfbs_pkg::*;

  localparam int TOP_W = CHAN_W + FRACTION_BITS;
  localparam int V_W   = TOP_W + FRACTION_BITS + 1;
  localparam int WT_W  = FRACTION_BITS + 1;

  logic                    b1_v_r;
  logic [2:0][TOP_W-1:0]   top_r;
  logic [2:0][TOP_W-1:0]   bot_r;
  logic [FRAC_W-1:0]       b1_fy_r;
  logic                    o_v_r;
  rgb_t                    o_rgb_r;

  logic o_rdy, b1_rdy;
  rgb_t c00, c10, c01, c11;
  logic [WT_W-1:0] wx0, wx1, wy0, wy1;
  logic [2:0][TOP_W-1:0] top_nxt, bot_nxt;
  logic [V_W-1:0] v;
  rgb_t rgb_nxt;

  assign o_rdy      = !o_v_r || out_bus.ready;
  assign b1_rdy     = !b1_v_r || o_rdy;
  assign quad_ready = b1_rdy;

  assign out_bus.valid = o_v_r;
  assign out_bus.red   = o_rgb_r[2];
  assign out_bus.green = o_rgb_r[1];
  assign out_bus.blue  = o_rgb_r[0];
  assign out_bus.alpha = ALPHA_OPAQUE;

  // Horizontal blend; each sum is at most a channel times one.
  always_comb begin
    c00 = palette(quad.idx[0]);
    c10 = palette(quad.idx[1]);
    c01 = palette(quad.idx[2]);
    c11 = palette(quad.idx[3]);
    wx1 = WT_W'(quad.fx);
    wx0 = WT_W'(FX_ONE) - wx1;
    for (int ch = 0; ch < 3; ch++) begin
      top_nxt[ch] = TOP_W'((TOP_W+1)'(c00[ch]) * (TOP_W+1)'(wx0)
                         + (TOP_W+1)'(c10[ch]) * (TOP_W+1)'(wx1));
      bot_nxt[ch] = TOP_W'((TOP_W+1)'(c01[ch]) * (TOP_W+1)'(wx0)
                         + (TOP_W+1)'(c11[ch]) * (TOP_W+1)'(wx1));
    end
  end

  // Vertical blend, then drop both fractions.
  always_comb begin
    wy1 = WT_W'(b1_fy_r);
    wy0 = WT_W'(FX_ONE) - wy1;
    v   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = V_W'(top_r[ch]) * V_W'(wy0) + V_W'(bot_r[ch]) * V_W'(wy1);
      rgb_nxt[ch] = v[2*FRACTION_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (b1_rdy) b1_v_r <= quad_valid;
      if (o_rdy)  o_v_r  <= b1_v_r;
    end
    if (b1_rdy) begin
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      b1_fy_r <= quad.fy;
    end
    if (o_rdy) o_rgb_r <= rgb_nxt;
  end

endmodule
`default_nettype wire

### rtl/palette_frame_bilinear_scaler_unit.sv
// A sample beat passes three mapping stages, four frame reads, the done
// register and two blend stages on its way to its pixel beat.
// Samples are paced by the four reads on the single-port frame memory; a
// frame write is one access; new beats enter while older ones are in flight.
// Reset clears the pipeline valids and the registers (scales to 1.0, start 0);
// the frame memory is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module palette_frame_bilinear_scaler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pfbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  pfbs_in_if.sink                           in_bus,
  pfbs_out_if.source                        out_bus
);
  import pfbs_pkg::*;

  fetch_req_t req;
  logic       req_valid, req_ready;
  quad_t      quad;
  logic       quad_valid, quad_ready;

  pfbs_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready)
  );

  pfbs_fetch u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .quad       (quad),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready)
  );

  pfbs_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad       (quad),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .out_bus    (out_bus)
  );

endmodule
`default_nettype wire

### bench/pfbs_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the palette frame scaler: watches the config port and both beat channels,
// predicts each pixel from its own frame copy and compares. Depends on pfbs_pkg and pfbs_if.
module pfbs_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfbs_pkg::CFG_DATA_W-1:0] cfg_data,
  pfbs_in_if                              in_mon,
  pfbs_out_if                             out_mon,
  output int                              fail_count,
  output int                              pending
);
  import pfbs_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

  logic [7:0] shade_r [16] = '{0, 255, 190, 48, 180, 31, 33, 223, 184, 106, 254, 66, 112, 89,
                               85, 164};
  logic [7:0] shade_g [16] = '{0, 255, 26, 230, 26, 210, 27, 246, 65, 51, 74, 69, 116, 254,
                               83, 167};
  logic [7:0] shade_b [16] = '{0, 255, 36, 198, 226, 30, 174, 10, 4, 4, 87, 64, 111, 89,
                               254, 162};

  logic [31:0]          frame_copy [FRAME_DEPTH];
  logic [LINE_W-1:0]    line_reg;
  logic [SCALE_W-1:0]   sx_reg;
  logic [SCALE_W-1:0]   sy_reg;
  pixel_t               pixel_q[$];

  assign pending = pixel_q.size();

  initial fail_count = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Maps one output coordinate to a source pixel and fraction along one axis.
  function automatic void map_axis(input logic [DEST_W-1:0] d, input logic [SCALE_W-1:0] s,
                                   input int size, output int i0, output logic [63:0] f);
    logic [63:0] p;
    logic [63:0] pt;
    p = (64'(d) * 2 + 1) * 64'(s);
    pt = (p <= ONE) ? 64'd0 : ((p - ONE) >> 1);
    if (pt >= 64'(size - 1) * ONE) begin
      i0 = size - 2;
      f = 64'(TOP_FRAC);
    end else begin
      i0 = int'(pt >> FRACTION_BITS);
      f = pt & (ONE - 1);
    end
  endfunction

  function automatic logic [3:0] nibble_at(input int row, input int col);
    int src_row;
    int addr;
    src_row = (row + int'(line_reg)) % ROW_COUNT;
    addr = src_row * WORDS_PER_ROW + col / PIXELS_IN_WORD;
    return frame_copy[addr][4 * (col % PIXELS_IN_WORD) +: 4];
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] c00, input logic [7:0] c10,
                                       input logic [7:0] c01, input logic [7:0] c11,
                                       input logic [63:0] fx, input logic [63:0] fy);
    logic [63:0] top;
    logic [63:0] bot;
    logic [63:0] v;
    top = 64'(c00) * (ONE - fx) + 64'(c10) * fx;
    bot = 64'(c01) * (ONE - fx) + 64'(c11) * fx;
    v = (top * (ONE - fy) + bot * fy) >> (2 * FRACTION_BITS);
    return v[7:0];
  endfunction

  function automatic pixel_t predict_pixel(input logic [DEST_W-1:0] dx,
                                           input logic [DEST_W-1:0] dy);
    int x0;
    int y0;
    logic [63:0] fx;
    logic [63:0] fy;
    logic [3:0] a, b, c, d;
    pixel_t px;
    map_axis(dx, sx_reg, ROW_PIXELS, x0, fx);
    map_axis(dy, sy_reg, ROW_COUNT, y0, fy);
    a = nibble_at(y0, x0);
    b = nibble_at(y0, x0 + 1);
    c = nibble_at(y0 + 1, x0);
    d = nibble_at(y0 + 1, x0 + 1);
    px.red   = blend(shade_r[a], shade_r[b], shade_r[c], shade_r[d], fx, fy);
    px.green = blend(shade_g[a], shade_g[b], shade_g[c], shade_g[d], fx, fy);
    px.blue  = blend(shade_b[a], shade_b[b], shade_b[c], shade_b[d], fx, fy);
    return px;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      line_reg <= '0;
      sx_reg <= SCALE_W'(FX_ONE);
      sy_reg <= SCALE_W'(FX_ONE);
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_START_LINE: line_reg <= cfg_data[LINE_W-1:0];
          CFG_SCALE_X:    sx_reg <= cfg_data[SCALE_W-1:0];
          CFG_SCALE_Y:    sy_reg <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (action_t'(in_mon.action) == ACT_WRITE) begin
          if (in_mon.word_address < FRAME_DEPTH)
            frame_copy[in_mon.word_address] = in_mon.word_data;
        end else begin
          pixel_q.push_back(predict_pixel(in_mon.dest_x, in_mon.dest_y));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected pixel beat", 0, 0);
        end else begin
          pixel_t want;
          want = pixel_q.pop_front();
          if (out_mon.red !== want.red) report("red", out_mon.red, want.red);
          if (out_mon.green !== want.green) report("green", out_mon.green, want.green);
          if (out_mon.blue !== want.blue) report("blue", out_mon.blue, want.blue);
          if (out_mon.alpha !== ALPHA_OPAQUE) report("alpha", out_mon.alpha, ALPHA_OPAQUE);
        end
      end
    end
  end
endmodule

### bench/palette_frame_bilinear_scaler_unit_tb.sv
`timescale 1ns / 1ps
// Top of the palette frame scaler bench: clock, reset, frame fill, directed and random beats.
// Depends on pfbs_pkg, pfbs_if, the scaler RTL and pfbs_scoreboard.
module palette_frame_bilinear_scaler_unit_tb;
  import pfbs_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  pfbs_in_if in_bus ();
  pfbs_out_if out_bus ();

  palette_frame_bilinear_scaler_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_bus(in_bus), .out_bus(out_bus)
  );

  pfbs_scoreboard scoreboard (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mon(in_bus), .out_mon(out_bus), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL palette_frame_bilinear_scaler_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input action_t act, input logic [ADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] data, input logic [DEST_W-1:0] dx,
                           input logic [DEST_W-1:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.word_address <= addr;
    in_bus.word_data <= data;
    in_bus.dest_x <= dx;
    in_bus.dest_y <= dy;
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic sample_at(input int dx, input int dy);
    send_beat(ACT_SAMPLE, ADDR_W'($urandom), $urandom, DEST_W'(dx), DEST_W'(dy));
  endtask

  // Holds the sender off until every pixel is out and the pipeline has emptied.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scaling(input int line, input int sx, input int sy);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_LINE;
    cfg_data <= CFG_DATA_W'(line);
    @(posedge clk);
    cfg_index <= CFG_SCALE_X;
    cfg_data <= CFG_DATA_W'(sx);
    @(posedge clk);
    cfg_index <= CFG_SCALE_Y;
    cfg_data <= CFG_DATA_W'(sy);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_beat();
    int dx;
    int dy;
    logic [ADDR_W-1:0] addr;
    if ($urandom_range(99) < 30) begin
      addr = ($urandom_range(9) == 0) ? ADDR_W'($urandom)
                                      : ADDR_W'($urandom_range(FRAME_DEPTH - 1));
      send_beat(ACT_WRITE, addr, $urandom, DEST_W'($urandom), DEST_W'($urandom));
    end else begin
      case ($urandom_range(3))
        0: begin dx = $urandom_range(16383); dy = $urandom_range(16383); end
        1: begin dx = $urandom_range(9999); dy = $urandom_range(9999); end
        default: begin dx = $urandom_range(ROW_PIXELS); dy = $urandom_range(ROW_COUNT); end
      endcase
      sample_at(dx, dy);
    end
  endtask

  initial begin
    int lines [6];
    int scx [6];
    int scy [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START_LINE;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_WRITE;
    in_bus.word_address = '0;
    in_bus.word_data = '0;
    in_bus.dest_x = '0;
    in_bus.dest_y = '0;
    out_bus.ready = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 57;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every frame word is written first, so no sample ever reads an unwritten word.
    for (int i = 0; i < FRAME_DEPTH; i++) send_beat(ACT_WRITE, ADDR_W'(i), $urandom, '0, '0);

    send_beat(ACT_WRITE, '0, 32'h0000_0000, '0, '0);
    send_beat(ACT_WRITE, ADDR_W'(FRAME_DEPTH - 1), 32'hFFFF_FFFF, '1, '1);
    send_beat(ACT_WRITE, ADDR_W'(WORDS_PER_ROW), 32'hFEDC_BA98, '0, '0);
    send_beat(ACT_WRITE, ADDR_W'(WORDS_PER_ROW + 1), 32'h7654_3210, '0, '0);
    // Writes past the end of the frame must be dropped.
    send_beat(ACT_WRITE, ADDR_W'(FRAME_DEPTH), 32'h1111_1111, '0, '0);
    send_beat(ACT_WRITE, '1, 32'h2222_2222, '0, '0);
    sample_at(0, 0);
    sample_at(1, 0);
    sample_at(0, 1);
    sample_at(ROW_PIXELS - 1, ROW_COUNT - 1);
    sample_at(ROW_PIXELS - 2, ROW_COUNT - 2);
    sample_at(9999, 9999);
    sample_at(16383, 16383);
    sample_at(5, 311);
    sample_at(415, 3);
    settle();
    set_scaling(311, 1, 27787264);
    sample_at(0, 0);
    sample_at(16383, 0);
    sample_at(0, 16383);
    settle();
    set_scaling(511, 0, 33554431);
    sample_at(0, 0);
    sample_at(9999, 1);
    sample_at(7, 16383);
    settle();

    lines = '{0, 311, 511, 0, 0, 1};
    scx = '{65536, 27787264, 0, 0, 0, 32768};
    scy = '{65536, 1, 33554431, 0, 0, 98304};
    lines[3] = $urandom_range(311);
    scx[3] = $urandom_range(16384, 262144);
    scy[3] = $urandom_range(16384, 262144);
    lines[4] = $urandom_range(511);
    scx[4] = $urandom_range(33554431);
    scy[4] = $urandom_range(33554431);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 57;
      end else if (ph < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_scaling(lines[ph], scx[ph], scy[ph]);
      repeat (200) random_beat();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS palette_frame_bilinear_scaler_unit");
    end else begin
      $display("FAIL palette_frame_bilinear_scaler_unit");
    end
    $finish;
  end
endmodule
